/* sv/vector_host_seir_derivative_defines.svh */
// Assertion macros for the vector-host SEIR derivative block.
// Needs clk and rst_n in the scope that uses them; no other dependencies.
`ifndef VECTOR_HOST_SEIR_DERIVATIVE_DEFINES_SVH
`define VECTOR_HOST_SEIR_DERIVATIVE_DEFINES_SVH

// same-cycle implication, held off during reset
`define VHSD_ASSERT_NOW(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("vhsd assertion failed");

// next-cycle implication, held off during reset
`define VHSD_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("vhsd assertion failed");

`endif

/* sv/vhsd_pkg.sv */
// Shared types and constants of the vector-host SEIR derivative block.
// No dependencies; used by vhsd_frac_div and vector_host_seir_derivative.
package vhsd_pkg;

    localparam int CNT_W   = 40;
    localparam int RATE_W  = 32;
    localparam int DER_W   = 48;
    localparam int SUM_W   = 42;
    localparam int FRAC_W  = 33;
    localparam int FRAC_BITS = 32;

    // divider: one compare step up front, then DIV_STEPS restoring steps per stage
    localparam int DIV_STEPS = 2;
    localparam int DIV_LAT   = 1 + FRAC_BITS / DIV_STEPS;

    // pipeline stage indices
    localparam int ST_A    = 0;
    localparam int ST_MUL  = DIV_LAT + 1;
    localparam int ST_PP   = ST_MUL + 1;
    localparam int ST_FLOW = ST_PP + 1;
    localparam int ST_OUT  = ST_FLOW + 1;
    localparam int N_ST    = ST_OUT + 1;

    typedef enum logic [2:0] {
        REG_MOSQ_DEATH = 3'd0,
        REG_HUM_DEATH  = 3'd1,
        REG_MOSQ_INC   = 3'd2,
        REG_HUM_INC    = 3'd3,
        REG_HUM_REC    = 3'd4,
        REG_BETA_M     = 3'd5,
        REG_BETA_H     = 3'd6,
        REG_SEED_END   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0]      sim_time;
        logic [CNT_W-1:0] mosquito_susceptible;
        logic [CNT_W-1:0] mosquito_exposed;
        logic [CNT_W-1:0] mosquito_infected;
        logic [CNT_W-1:0] human_susceptible;
        logic [CNT_W-1:0] human_exposed;
        logic [CNT_W-1:0] human_infected;
        logic [CNT_W-1:0] human_recovered;
    } item_t;

    typedef struct packed {
        logic signed [DER_W-1:0] d_mosquito_susceptible;
        logic signed [DER_W-1:0] d_mosquito_exposed;
        logic signed [DER_W-1:0] d_mosquito_infected;
        logic signed [DER_W-1:0] d_human_susceptible;
        logic signed [DER_W-1:0] d_human_exposed;
        logic signed [DER_W-1:0] d_human_infected;
        logic signed [DER_W-1:0] d_human_recovered;
        logic signed [DER_W-1:0] d_incidence;
        logic                    empty_population;
    } result_t;

endpackage

/* sv/vhsd_frac_div.sv */
// Pipelined restoring divider, two lanes sharing one denominator: floor(x*2^32/n).
// Uses vhsd_pkg; stage enables come from the pipeline control of the top level.
module vhsd_frac_div (
    input  logic                              clk,
    input  logic [vhsd_pkg::DIV_LAT-1:0]      en,
    input  logic [vhsd_pkg::CNT_W-1:0]        num_i,
    input  logic [vhsd_pkg::CNT_W-1:0]        num_s,
    input  logic [vhsd_pkg::SUM_W-1:0]        den,
    output logic [vhsd_pkg::FRAC_W-1:0]       frac_i,
    output logic [vhsd_pkg::FRAC_W-1:0]       frac_s
);

    typedef struct packed {
        logic [vhsd_pkg::SUM_W-1:0]  rem;
        logic [vhsd_pkg::FRAC_W-1:0] quo;
    } div_st_t;

    div_st_t                    st_reg   [vhsd_pkg::DIV_LAT][2];
    div_st_t                    st_next  [vhsd_pkg::DIV_LAT][2];
    logic [vhsd_pkg::SUM_W-1:0] den_reg  [vhsd_pkg::DIV_LAT];

    function automatic div_st_t div_step(div_st_t s, logic [vhsd_pkg::SUM_W-1:0] n);
        logic [vhsd_pkg::SUM_W:0] r2;
        div_st_t                  o;
        r2    = {s.rem, 1'b0};
        o.quo = {s.quo[vhsd_pkg::FRAC_W-2:0], 1'b0};
        if (r2 >= {1'b0, n})
        begin
            o.rem    = vhsd_pkg::SUM_W'(r2 - {1'b0, n});
            o.quo[0] = 1'b1;
        end
        else
        begin
            o.rem = r2[vhsd_pkg::SUM_W-1:0];
        end
        return o;
    endfunction

    always_comb
    begin
        logic [vhsd_pkg::SUM_W-1:0] x [2];
        div_st_t                    t;
        x[0] = {2'b00, num_i};
        x[1] = {2'b00, num_s};
        for (int l = 0; l < 2; l++)
        begin
            // leading quotient bit: fraction can reach exactly one
            if (x[l] >= den)
            begin
                st_next[0][l].rem = x[l] - den;
                st_next[0][l].quo = vhsd_pkg::FRAC_W'(1);
            end
            else
            begin
                st_next[0][l].rem = x[l];
                st_next[0][l].quo = '0;
            end
        end
        for (int j = 1; j < vhsd_pkg::DIV_LAT; j++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                t = st_reg[j-1][l];
                for (int k = 0; k < vhsd_pkg::DIV_STEPS; k++)
                begin
                    t = div_step(t, den_reg[j-1]);
                end
                st_next[j][l] = t;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < vhsd_pkg::DIV_LAT; j++)
        begin
            if (en[j])
            begin
                st_reg[j][0] <= st_next[j][0];
                st_reg[j][1] <= st_next[j][1];
                den_reg[j]   <= (j == 0) ? den : den_reg[(j == 0) ? 0 : j-1];
            end
        end
    end

    assign frac_i = st_reg[vhsd_pkg::DIV_LAT-1][0].quo;
    assign frac_s = st_reg[vhsd_pkg::DIV_LAT-1][1].quo;

endmodule

/* sv/vector_host_seir_derivative.sv */
// Top level of the vector-host SEIR derivative block: config registers and pipeline.
// Uses vhsd_pkg, vhsd_frac_div and vector_host_seir_derivative_defines.svh.
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  item      | item_valid, item_stall, item_data         | in
//  result    | result_valid, result_stall, result_data   | out
//  cfg       | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// One item per cycle sustained while result_stall is low; results pass through the
// 17-stage fraction divider (a leading compare, then two quotient bits per stage).
// Each stage loads when it is empty or the stage after it moves, so bubbles close
// up under a result stall; item_stall rises only with every stage full.
// Reset clears stage valid bits and config registers; cfg_ready is always high.
`include "vector_host_seir_derivative_defines.svh"

module vector_host_seir_derivative (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  vhsd_pkg::item_t            item_data,
    output logic                       result_valid,
    input  logic                       result_stall,
    output vhsd_pkg::result_t          result_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [2:0]                 cfg_index,
    input  logic [31:0]                cfg_data
);

    typedef struct packed {
        vhsd_pkg::item_t             item;
        logic [vhsd_pkg::SUM_W-1:0]  nh;
        logic                        pre;
        logic                        empty;
    } side_t;

    typedef struct packed {
        logic [41:0] nm_m;
        logic [41:0] sm_m;
        logic [41:0] em_m;
        logic [41:0] im_m;
        logic [41:0] nh_h;
        logic [41:0] sh_h;
        logic [41:0] eh_h;
        logic [41:0] ih_h;
        logic [41:0] rh_h;
        logic [41:0] em_inc;
        logic [41:0] eh_inc;
        logic [41:0] ih_rec;
        logic        pre;
        logic        empty;
    } term_t;

    logic [31:0] rate_reg [8];

    logic [vhsd_pkg::N_ST-1:0] v_reg;
    logic [vhsd_pkg::N_ST-1:0] adv;

    vhsd_pkg::item_t             a_reg;
    logic [vhsd_pkg::SUM_W-1:0]  nh_a_reg;
    logic                        pre_a_reg;
    side_t                       side_reg [vhsd_pkg::DIV_LAT];

    logic [vhsd_pkg::FRAC_W-1:0] frac_i;
    logic [vhsd_pkg::FRAC_W-1:0] frac_s;

    term_t        mul_reg;
    logic [47:0]  bm_reg;
    logic [47:0]  bh_reg;
    logic [32:0]  fi_reg;
    logic [32:0]  fs_reg;

    term_t        pp_term_reg;
    logic [56:0]  pm_lo_reg;
    logic [56:0]  pm_hi_reg;
    logic [56:0]  ph_lo_reg;
    logic [56:0]  ph_hi_reg;

    term_t        fl_term_reg;
    logic [48:0]  flow_m_reg;
    logic [48:0]  flow_h_reg;

    vhsd_pkg::result_t out_reg;
    vhsd_pkg::result_t out_next;

    function automatic logic [41:0] mul_rate(logic [41:0] a, logic [31:0] r);
        logic [73:0] p;
        p = a * r;
        return p[73:32];
    endfunction

    function automatic logic [47:0] mul_beta(logic [39:0] a, logic [31:0] r);
        logic [71:0] p;
        p = a * r;
        return p[71:24];
    endfunction

    function automatic logic signed [51:0] ext(logic [48:0] a);
        return $signed({3'b000, a});
    endfunction

    function automatic logic signed [47:0] sat_der(logic signed [51:0] v);
        logic signed [51:0] hi;
        logic signed [51:0] lo;
        hi = 52'sd140737488355327;
        lo = -52'sd140737488355328;
        if (v > hi)
            return hi[47:0];
        else if (v < lo)
            return lo[47:0];
        else
            return v[47:0];
    endfunction

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                rate_reg[i] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (vhsd_pkg::cfg_idx_t'(cfg_index))
                vhsd_pkg::REG_MOSQ_DEATH: rate_reg[vhsd_pkg::REG_MOSQ_DEATH] <= cfg_data;
                vhsd_pkg::REG_HUM_DEATH:  rate_reg[vhsd_pkg::REG_HUM_DEATH]  <= cfg_data;
                vhsd_pkg::REG_MOSQ_INC:   rate_reg[vhsd_pkg::REG_MOSQ_INC]   <= cfg_data;
                vhsd_pkg::REG_HUM_INC:    rate_reg[vhsd_pkg::REG_HUM_INC]    <= cfg_data;
                vhsd_pkg::REG_HUM_REC:    rate_reg[vhsd_pkg::REG_HUM_REC]    <= cfg_data;
                vhsd_pkg::REG_BETA_M:     rate_reg[vhsd_pkg::REG_BETA_M]     <= cfg_data;
                vhsd_pkg::REG_BETA_H:     rate_reg[vhsd_pkg::REG_BETA_H]     <= cfg_data;
                vhsd_pkg::REG_SEED_END:   rate_reg[vhsd_pkg::REG_SEED_END]   <= cfg_data;
                default:                  rate_reg[0] <= rate_reg[0];
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    always_comb
    begin
        adv[vhsd_pkg::ST_OUT] = !v_reg[vhsd_pkg::ST_OUT] || !result_stall;
        for (int k = vhsd_pkg::ST_OUT - 1; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k+1];
    end

    assign item_stall   = !adv[vhsd_pkg::ST_A];
    assign result_valid = v_reg[vhsd_pkg::ST_OUT];
    assign result_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
                v_reg[0] <= item_valid;
            for (int k = 1; k < vhsd_pkg::N_ST; k++)
            begin
                if (adv[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // ---------------- stage A: capture, totals, seeding compare ----------------
    always_ff @(posedge clk)
    begin
        if (adv[vhsd_pkg::ST_A])
        begin
            a_reg     <= item_data;
            nh_a_reg  <= {2'b00, item_data.human_susceptible} + {2'b00, item_data.human_exposed}
                       + {2'b00, item_data.human_infected} + {2'b00, item_data.human_recovered};
            pre_a_reg <= item_data.sim_time < rate_reg[vhsd_pkg::REG_SEED_END];
        end
    end

    // ---------------- divider stages with side line ----------------
    vhsd_frac_div u_div (
        .clk    (clk),
        .en     (adv[vhsd_pkg::DIV_LAT:1]),
        .num_i  (a_reg.human_infected),
        .num_s  (a_reg.human_susceptible),
        .den    (nh_a_reg),
        .frac_i (frac_i),
        .frac_s (frac_s)
    );

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < vhsd_pkg::DIV_LAT; j++)
        begin
            if (adv[j+1])
            begin
                if (j == 0)
                begin
                    side_reg[0].item  <= a_reg;
                    side_reg[0].nh    <= nh_a_reg;
                    side_reg[0].pre   <= pre_a_reg;
                    side_reg[0].empty <= (nh_a_reg == '0);
                end
                else
                begin
                    side_reg[j] <= side_reg[(j == 0) ? 0 : j-1];
                end
            end
        end
    end

    // ---------------- rate products ----------------
    always_ff @(posedge clk)
    begin
        side_t       s;
        logic [41:0] nm;
        logic [41:0] sh_op;
        s     = side_reg[vhsd_pkg::DIV_LAT-1];
        nm    = {2'b00, s.item.mosquito_susceptible} + {2'b00, s.item.mosquito_exposed}
              + {2'b00, s.item.mosquito_infected};
        // before seeding, infected humans count as susceptible for turnover
        sh_op = s.pre ? ({2'b00, s.item.human_susceptible} + {2'b00, s.item.human_infected})
                      : {2'b00, s.item.human_susceptible};
        if (adv[vhsd_pkg::ST_MUL])
        begin
            mul_reg.nm_m   <= mul_rate(nm, rate_reg[vhsd_pkg::REG_MOSQ_DEATH]);
            mul_reg.sm_m   <= mul_rate({2'b00, s.item.mosquito_susceptible},
                                       rate_reg[vhsd_pkg::REG_MOSQ_DEATH]);
            mul_reg.em_m   <= mul_rate({2'b00, s.item.mosquito_exposed},
                                       rate_reg[vhsd_pkg::REG_MOSQ_DEATH]);
            mul_reg.im_m   <= mul_rate({2'b00, s.item.mosquito_infected},
                                       rate_reg[vhsd_pkg::REG_MOSQ_DEATH]);
            mul_reg.nh_h   <= mul_rate(s.nh, rate_reg[vhsd_pkg::REG_HUM_DEATH]);
            mul_reg.sh_h   <= mul_rate(sh_op, rate_reg[vhsd_pkg::REG_HUM_DEATH]);
            mul_reg.eh_h   <= mul_rate({2'b00, s.item.human_exposed},
                                       rate_reg[vhsd_pkg::REG_HUM_DEATH]);
            mul_reg.ih_h   <= mul_rate({2'b00, s.item.human_infected},
                                       rate_reg[vhsd_pkg::REG_HUM_DEATH]);
            mul_reg.rh_h   <= mul_rate({2'b00, s.item.human_recovered},
                                       rate_reg[vhsd_pkg::REG_HUM_DEATH]);
            mul_reg.em_inc <= mul_rate({2'b00, s.item.mosquito_exposed},
                                       rate_reg[vhsd_pkg::REG_MOSQ_INC]);
            mul_reg.eh_inc <= mul_rate({2'b00, s.item.human_exposed},
                                       rate_reg[vhsd_pkg::REG_HUM_INC]);
            mul_reg.ih_rec <= mul_rate({2'b00, s.item.human_infected},
                                       rate_reg[vhsd_pkg::REG_HUM_REC]);
            mul_reg.pre    <= s.pre;
            mul_reg.empty  <= s.empty;
            bm_reg <= mul_beta(s.item.mosquito_susceptible, rate_reg[vhsd_pkg::REG_BETA_M]);
            bh_reg <= mul_beta(s.item.mosquito_infected, rate_reg[vhsd_pkg::REG_BETA_H]);
            fi_reg <= frac_i;
            fs_reg <= frac_s;
        end
    end

    // ---------------- flow partial products: 24-bit halves times fraction ----------------
    always_ff @(posedge clk)
    begin
        if (adv[vhsd_pkg::ST_PP])
        begin
            pp_term_reg <= mul_reg;
            pm_lo_reg   <= bm_reg[23:0] * fi_reg;
            pm_hi_reg   <= bm_reg[47:24] * fi_reg;
            ph_lo_reg   <= bh_reg[23:0] * fs_reg;
            ph_hi_reg   <= bh_reg[47:24] * fs_reg;
        end
    end

    // ---------------- flow sums and seeding/empty gating ----------------
    always_ff @(posedge clk)
    begin
        logic [80:0] fm;
        logic [80:0] fh;
        logic        no_flow;
        term_t       tm;
        fm      = {pm_hi_reg, 24'b0} + {24'b0, pm_lo_reg};
        fh      = {ph_hi_reg, 24'b0} + {24'b0, ph_lo_reg};
        no_flow = pp_term_reg.pre || pp_term_reg.empty;
        tm      = pp_term_reg;
        if (pp_term_reg.pre)
        begin
            tm.em_inc = '0;
            tm.eh_inc = '0;
            tm.ih_rec = '0;
        end
        if (adv[vhsd_pkg::ST_FLOW])
        begin
            fl_term_reg <= tm;
            flow_m_reg  <= no_flow ? '0 : fm[80:32];
            flow_h_reg  <= no_flow ? '0 : fh[80:32];
        end
    end

    // ---------------- derivatives and saturation ----------------
    always_comb
    begin
        term_t t;
        t = fl_term_reg;
        out_next.d_mosquito_susceptible = sat_der(ext({7'b0, t.nm_m}) - ext({7'b0, t.sm_m})
                                                  - ext(flow_m_reg));
        out_next.d_mosquito_exposed     = sat_der(ext(flow_m_reg) - ext({7'b0, t.em_m})
                                                  - ext({7'b0, t.em_inc}));
        out_next.d_mosquito_infected    = sat_der(ext({7'b0, t.em_inc}) - ext({7'b0, t.im_m}));
        out_next.d_human_susceptible    = sat_der(ext({7'b0, t.nh_h}) - ext({7'b0, t.sh_h})
                                                  - ext(flow_h_reg));
        out_next.d_human_exposed        = sat_der(ext(flow_h_reg) - ext({7'b0, t.eh_h})
                                                  - ext({7'b0, t.eh_inc}));
        out_next.d_human_infected       = t.pre ? '0
                                        : sat_der(ext({7'b0, t.eh_inc}) - ext({7'b0, t.ih_h})
                                                  - ext({7'b0, t.ih_rec}));
        out_next.d_human_recovered      = sat_der(ext({7'b0, t.ih_rec}) - ext({7'b0, t.rh_h}));
        out_next.d_incidence            = t.pre ? '0
                                        : sat_der(ext({7'b0, t.eh_inc}) - ext({7'b0, t.eh_h}));
        out_next.empty_population       = t.empty;
    end

    always_ff @(posedge clk)
    begin
        if (adv[vhsd_pkg::ST_OUT])
            out_reg <= out_next;
    end

    // ---------------- assertions ----------------
    `VHSD_ASSERT_NOW(a_stall_full, item_stall, $countones(v_reg) == vhsd_pkg::N_ST)
    `VHSD_ASSERT_NOW(a_stall_cause, item_stall, result_valid && result_stall)
    `VHSD_ASSERT_NEXT(a_accept_fills, item_valid && !item_stall, v_reg[vhsd_pkg::ST_A])

endmodule

/* tb/vector_host_seir_derivative_tb.sv */
// Testbench for vector_host_seir_derivative: directed and random items checked
// against an in-bench fixed-point predictor. Depends on vhsd_pkg and the block.
`timescale 1ns / 100ps

module vector_host_seir_derivative_tb;

    localparam int LATENCY   = 22;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [39:0] CNT_MAX = 40'hFF_FFFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    vhsd_pkg::item_t   item_data;
    logic        result_valid;
    logic        result_stall;
    vhsd_pkg::result_t result_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    logic [31:0] rates [8];
    vhsd_pkg::result_t expected_derivs [$];
    int          mismatches = 0;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;
    int          quiet_cycles = 0;

    vector_host_seir_derivative DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // floor(a*b / 2^s), saturating at all ones of 64 bits
    function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = (a * 128'd1) * b;
        p = p >> s;
        if (p[127:64] != 0)
            return '1;
        return p[63:0];
    endfunction

    // floor(x*2^32 / n)
    function automatic logic [63:0] share_of(logic [63:0] x, logic [63:0] n);
        logic [127:0] num;
        num = (x * 128'd1) << 32;
        return 64'(num / n);
    endfunction

    function automatic logic signed [47:0] clamp48(logic signed [127:0] v);
        if (v > 128'sd140737488355327)
            return 48'sh7FFF_FFFF_FFFF;
        if (v < -128'sd140737488355328)
            return 48'sh8000_0000_0000;
        return v[47:0];
    endfunction

    function automatic vhsd_pkg::result_t predict_derivs(vhsd_pkg::item_t it);
        logic signed [127:0] d [8];
        logic signed [127:0] mul_m, flow_m, flow_h, em_m, em_inc, eh_h, eh_inc, ih_rec;
        logic [63:0] sm, em, im, sh, eh, ih, rh, nm, nh;
        logic [63:0] m, h;
        vhsd_pkg::result_t r;
        sm = it.mosquito_susceptible; em = it.mosquito_exposed; im = it.mosquito_infected;
        sh = it.human_susceptible; eh = it.human_exposed; ih = it.human_infected;
        rh = it.human_recovered;
        m = rates[vhsd_pkg::REG_MOSQ_DEATH]; h = rates[vhsd_pkg::REG_HUM_DEATH];
        nm = sm + em + im;
        nh = sh + eh + ih + rh;
        mul_m = scaled_product(nm, m, 32);
        if (it.sim_time < rates[vhsd_pkg::REG_SEED_END])
        begin
            d[0] = mul_m - scaled_product(sm, m, 32);
            d[1] = -scaled_product(em, m, 32);
            d[2] = -scaled_product(im, m, 32);
            d[3] = scaled_product(nh, h, 32) - scaled_product(sh + ih, h, 32);
            d[4] = -scaled_product(eh, h, 32);
            d[5] = 0;
            d[6] = -scaled_product(rh, h, 32);
            d[7] = 0;
        end
        else
        begin
            flow_m = 0;
            flow_h = 0;
            em_m   = scaled_product(em, m, 32);
            em_inc = scaled_product(em, rates[vhsd_pkg::REG_MOSQ_INC], 32);
            eh_h   = scaled_product(eh, h, 32);
            eh_inc = scaled_product(eh, rates[vhsd_pkg::REG_HUM_INC], 32);
            ih_rec = scaled_product(ih, rates[vhsd_pkg::REG_HUM_REC], 32);
            if (nh != 0)
            begin
                flow_m = scaled_product(scaled_product(sm, rates[vhsd_pkg::REG_BETA_M], 24),
                                        share_of(ih, nh), 32);
                flow_h = scaled_product(scaled_product(im, rates[vhsd_pkg::REG_BETA_H], 24),
                                        share_of(sh, nh), 32);
            end
            d[0] = mul_m - scaled_product(sm, m, 32) - flow_m;
            d[1] = flow_m - em_m - em_inc;
            d[2] = em_inc - scaled_product(im, m, 32);
            d[3] = scaled_product(nh, h, 32) - scaled_product(sh, h, 32) - flow_h;
            d[4] = flow_h - eh_h - eh_inc;
            d[5] = eh_inc - scaled_product(ih, h, 32) - ih_rec;
            d[6] = ih_rec - scaled_product(rh, h, 32);
            d[7] = eh_inc - eh_h;
        end
        r.d_mosquito_susceptible = clamp48(d[0]);
        r.d_mosquito_exposed     = clamp48(d[1]);
        r.d_mosquito_infected    = clamp48(d[2]);
        r.d_human_susceptible    = clamp48(d[3]);
        r.d_human_exposed        = clamp48(d[4]);
        r.d_human_infected       = clamp48(d[5]);
        r.d_human_recovered      = clamp48(d[6]);
        r.d_incidence            = clamp48(d[7]);
        r.empty_population       = (nh == 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        mismatches++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    endtask

    // result side: stall at random, check each transfer
    always @(posedge clk)
    begin
        vhsd_pkg::result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_derivs.size() == 0)
                    report_mismatch("unexpected result", '0, '0);
                else
                begin
                    want = expected_derivs.pop_front();
                    if (result_data.d_mosquito_susceptible != want.d_mosquito_susceptible)
                        report_mismatch("d_mosquito_susceptible",
                            result_data.d_mosquito_susceptible, want.d_mosquito_susceptible);
                    if (result_data.d_mosquito_exposed != want.d_mosquito_exposed)
                        report_mismatch("d_mosquito_exposed",
                            result_data.d_mosquito_exposed, want.d_mosquito_exposed);
                    if (result_data.d_mosquito_infected != want.d_mosquito_infected)
                        report_mismatch("d_mosquito_infected",
                            result_data.d_mosquito_infected, want.d_mosquito_infected);
                    if (result_data.d_human_susceptible != want.d_human_susceptible)
                        report_mismatch("d_human_susceptible",
                            result_data.d_human_susceptible, want.d_human_susceptible);
                    if (result_data.d_human_exposed != want.d_human_exposed)
                        report_mismatch("d_human_exposed",
                            result_data.d_human_exposed, want.d_human_exposed);
                    if (result_data.d_human_infected != want.d_human_infected)
                        report_mismatch("d_human_infected",
                            result_data.d_human_infected, want.d_human_infected);
                    if (result_data.d_human_recovered != want.d_human_recovered)
                        report_mismatch("d_human_recovered",
                            result_data.d_human_recovered, want.d_human_recovered);
                    if (result_data.d_incidence != want.d_incidence)
                        report_mismatch("d_incidence", result_data.d_incidence,
                                        want.d_incidence);
                    if (result_data.empty_population != want.empty_population)
                        report_mismatch("empty_population", result_data.empty_population,
                                        want.empty_population);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog: cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // valid stays high after the transfer; the next idle cycle or a drain drops it
    task automatic send_item(vhsd_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        expected_derivs.push_back(predict_derivs(it));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (expected_derivs.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_rate(vhsd_pkg::cfg_idx_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        rates[idx] = value;
        @(negedge clk);
    endtask

    task automatic write_all_rates(logic [31:0] v [8]);
        for (int i = 0; i < 8; i++)
            write_rate(vhsd_pkg::cfg_idx_t'(i), v[i]);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [39:0] rand_count();
        case ($urandom_range(5))
            0: return '0;
            1: return CNT_MAX;
            2: return 40'($urandom_range(255));
            3: return {8'h00, $urandom()};
            default: return {8'($urandom()), $urandom()};
        endcase
    endfunction

    function automatic logic [31:0] rand_rate();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return 32'($urandom_range(65535));
            default: return $urandom();
        endcase
    endfunction

    function automatic vhsd_pkg::item_t rand_item();
        vhsd_pkg::item_t it;
        it.sim_time             = ($urandom_range(3) == 0) ? rates[vhsd_pkg::REG_SEED_END]
                                                           : $urandom();
        it.mosquito_susceptible = rand_count();
        it.mosquito_exposed     = rand_count();
        it.mosquito_infected    = rand_count();
        it.human_susceptible    = rand_count();
        it.human_exposed        = rand_count();
        it.human_infected       = rand_count();
        it.human_recovered      = rand_count();
        if ($urandom_range(9) == 0)
            {it.human_susceptible, it.human_exposed, it.human_infected,
             it.human_recovered} = 160'd0;
        return it;
    endfunction

    task automatic test_directed();
        vhsd_pkg::item_t it;
        logic [31:0] v [8];
        v = '{32'h0100_0000, 32'h0010_0000, 32'h2000_0000, 32'h1000_0000,
              32'h0800_0000, 32'h0080_0000, 32'h0040_0000, 32'h000A_0000};
        write_all_rates(v);
        for (int k = 0; k < 12; k++)
        begin
            it = '0;
            it.sim_time = (k % 2) ? 32'h0014_0000 : 32'h0001_0000;
            case (k / 2)
                0: ;                                   // all empty
                1: it = '{it.sim_time, CNT_MAX, CNT_MAX, CNT_MAX,
                          CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX};
                2: it = '{it.sim_time, 40'h10_0000, 40'h2_0000, 40'h1_0000,
                          40'h64_0000, 40'h5_0000, 40'h3_0000, 40'h1_0000};
                3: it = '{it.sim_time, CNT_MAX, 0, CNT_MAX, 0, 0, CNT_MAX, 0};
                4: it = '{it.sim_time, 40'h1, 40'h1, 40'h1, 40'h1, 40'h1, 40'h1, 40'h1};
                default: it = '{it.sim_time, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, 0, 0, 0};
            endcase
            send_item(it);
        end
        it = '{32'h000A_0000, 40'h1000, 40'h1000, 40'h1000, 40'h1000, 40'h1000,
               40'h1000, 40'h1000};
        send_item(it);                              // exactly at seeding time
        wait_drained();
        // all rates at maximum with the seeding end at zero, then all zero
        v = '{default: 32'hFFFF_FFFF};
        v[vhsd_pkg::REG_SEED_END] = 32'h0;
        write_all_rates(v);
        for (int k = 0; k < 5; k++)
            send_item(rand_item());
        it = '{32'hFFFF_FFFF, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX,
               CNT_MAX, CNT_MAX};
        send_item(it);
        wait_drained();
        v = '{default: 32'h0};
        write_all_rates(v);
        for (int k = 0; k < 4; k++)
            send_item(rand_item());
        wait_drained();
    endtask

    task automatic test_random(int n_items);
        logic [31:0] v [8];
        for (int ph = 0; ph < 6; ph++)
        begin
            for (int i = 0; i < 8; i++)
                v[i] = rand_rate();
            write_all_rates(v);
            for (int k = 0; k < n_items / 6; k++)
                send_item(rand_item());
            wait_drained();
        end
    endtask

    // receiver holds off long enough for the pipeline to fill and stall its input
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (4 * LATENCY) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 3 * LATENCY; k++)
                send_item(rand_item());
        join
        wait_drained();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item_data    = '0;
        cfg_valid    = 1'b0;
        cfg_index    = vhsd_pkg::REG_MOSQ_DEATH;
        cfg_data     = '0;
        hold_off     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 8; i++)
            rates[i] = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        send_idle_pct = 33;
        recv_idle_pct = 78;
        test_random(600);
        send_idle_pct = 78;
        recv_idle_pct = 33;
        test_random(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(600);

        wait_drained();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
